FILE: rtl/core/smsrng_pkg.sv
// Shared constants for the shuffled minimal-standard random number generator.
// Used by smsrng_lcg and shuffled_minimal_standard_rng; no dependencies.
`default_nettype none

package smsrng_pkg;

  // generator constants
  localparam int unsigned VAL_W   = 31;
  localparam int unsigned MULT_W  = 15;
  localparam int unsigned PROD_W  = VAL_W + MULT_W;
  localparam logic [MULT_W-1:0] MULT    = 15'd16807;
  localparam logic [VAL_W-1:0]  MODULUS = 31'h7FFF_FFFF;

  // shuffle table geometry
  localparam int unsigned TABLE_SIZE    = 32;
  localparam int unsigned IDX_W         = $clog2(TABLE_SIZE);
  localparam int unsigned BUCKET        = 1 + (32'h7FFF_FFFF - 1) / TABLE_SIZE;
  localparam int unsigned DISCARD_STEPS = 8;

  // seeding step counter
  localparam int unsigned SEED_STEPS = DISCARD_STEPS + TABLE_SIZE;
  localparam int unsigned CNT_W      = $clog2(SEED_STEPS);

endpackage

`default_nettype wire

FILE: rtl/core/smsrng_lcg.sv
// One step of the multiplicative congruential generator, x * 16807 mod 2^31-1.
// Product is registered, the Mersenne reduction follows in the next cycle.
// Depends on smsrng_pkg.
`default_nettype none

module smsrng_lcg (
  input  wire logic                            clk_i,
  input  wire logic                            mul_en_i,
  input  wire logic [smsrng_pkg::VAL_W-1:0]    x_i,
  output logic      [smsrng_pkg::VAL_W-1:0]    x_next_o
);

  logic [smsrng_pkg::PROD_W-1:0] prod_q;
  logic [smsrng_pkg::VAL_W:0]    sum;
  logic [smsrng_pkg::VAL_W:0]    modulus_ext;

  // product register
  always_ff @(posedge clk_i) begin
    if (mul_en_i) begin
      prod_q <= smsrng_pkg::PROD_W'(x_i) * smsrng_pkg::PROD_W'(smsrng_pkg::MULT);
    end
  end

  // fold high bits onto low bits, then one conditional subtract
  assign modulus_ext = {1'b0, smsrng_pkg::MODULUS};
  assign sum = {1'b0, prod_q[smsrng_pkg::VAL_W-1:0]}
             + (smsrng_pkg::VAL_W + 1)'(prod_q[smsrng_pkg::PROD_W-1:smsrng_pkg::VAL_W]);

  always_comb begin
    if (sum >= modulus_ext) begin
      x_next_o = smsrng_pkg::VAL_W'(sum - modulus_ext);
    end else begin
      x_next_o = sum[smsrng_pkg::VAL_W-1:0];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/shuffled_minimal_standard_rng.sv
// Top level of the shuffled minimal-standard random number generator.
// Depends on smsrng_pkg and smsrng_lcg.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o, field request_i): an item with
//   request 1 asks for one number; an item with request 0 is taken and dropped.
//   Output channel (out_valid_o / out_stall_i, field value_o): one 31-bit
//   value in 1 .. 2^31-2 per request, held in an output register.
//   Seed register: cfg_wdata_i is written when cfg_we_i is high; write it only
//   while the block is idle (the block does not enforce this); the write re-arms seeding.
//   Request path: without seeding, the table read and multiply happen at the
//   accepting edge, the reduction and write-back into the output register at
//   the next. No new request is taken until the last one is written back.
//   The first request after reset or a seed write runs seeding first: 40
//   generator steps, each a multiply state and a reduce state (8 discarded,
//   32 filling the table), then the table read and the write-back.
//   Reset: the seed returns to -1 and the generator is marked unseeded; the
//   table contents are left as they are and are refilled by seeding.
//   A stalled output holds its value; no new item is taken until it leaves.
`default_nettype none

module shuffled_minimal_standard_rng (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic                           request_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic      [smsrng_pkg::VAL_W-1:0]   value_o,
  input  wire logic                           cfg_we_i,
  input  wire logic signed [31:0]             cfg_wdata_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED_MUL,
    ST_SEED_RED,
    ST_REQ_ISSUE,
    ST_REQ_FIN
  } state_e;

  localparam logic [smsrng_pkg::CNT_W-1:0] LAST_CNT =
    smsrng_pkg::CNT_W'(smsrng_pkg::SEED_STEPS - 1);
  localparam logic [smsrng_pkg::CNT_W-1:0] DISCARD_CNT =
    smsrng_pkg::CNT_W'(smsrng_pkg::DISCARD_STEPS);

  state_e                          state_q;
  logic signed [31:0]              seed_q;
  logic [smsrng_pkg::VAL_W-1:0]    gen_q;
  logic [smsrng_pkg::VAL_W-1:0]    held_q;
  logic [smsrng_pkg::CNT_W-1:0]    cnt_q;
  logic [smsrng_pkg::IDX_W-1:0]    idx_q;
  logic [smsrng_pkg::VAL_W-1:0]    rd_q;
  logic                            out_valid_q;
  logic [smsrng_pkg::VAL_W-1:0]    out_value_q;

  logic [smsrng_pkg::VAL_W-1:0]    mem_q [smsrng_pkg::TABLE_SIZE];

  logic                            in_accept;
  logic                            issue;
  logic                            mul_en;
  logic [smsrng_pkg::VAL_W-1:0]    lcg_next;
  logic [smsrng_pkg::VAL_W-1:0]    bucket_quot;
  logic [smsrng_pkg::IDX_W-1:0]    idx;
  logic [31:0]                     seed_mag;
  logic [31:0]                     seed_red;
  logic [smsrng_pkg::VAL_W-1:0]    start_val;
  logic                            mem_we;
  logic [smsrng_pkg::IDX_W-1:0]    mem_waddr;
  logic [smsrng_pkg::CNT_W-1:0]    fill_sel;

  // handshake
  assign in_stall_o  = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign value_o     = out_value_q;

  // table read and generator step start together
  assign issue  = (state_q == ST_REQ_ISSUE)
               || (in_accept && request_i && (held_q != '0));
  assign mul_en = issue || (state_q == ST_SEED_MUL);

  // entry select from the previous output, wraps by truncation
  assign bucket_quot = smsrng_pkg::VAL_W'(held_q / smsrng_pkg::BUCKET);
  assign idx         = bucket_quot[smsrng_pkg::IDX_W-1:0];

  // start value: magnitude of a negative seed mod 2^31-1, else one; never zero
  assign seed_mag = 32'd0 - seed_q;
  assign seed_red = (seed_mag >= {1'b0, smsrng_pkg::MODULUS})
                  ? seed_mag - {1'b0, smsrng_pkg::MODULUS} : seed_mag;
  always_comb begin
    if (seed_q[31] && (seed_red != 32'd0)) begin
      start_val = seed_red[smsrng_pkg::VAL_W-1:0];
    end else begin
      start_val = smsrng_pkg::VAL_W'(1);
    end
  end

  // generator step unit
  smsrng_lcg u_lcg (
    .clk_i    (clk_i),
    .mul_en_i (mul_en),
    .x_i      (gen_q),
    .x_next_o (lcg_next)
  );

  // table write: fill from the top entry down, or replace the picked entry
  assign fill_sel = LAST_CNT - cnt_q;
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_q;
    if (state_q == ST_SEED_RED) begin
      mem_we    = (cnt_q >= DISCARD_CNT);
      mem_waddr = fill_sel[smsrng_pkg::IDX_W-1:0];
    end else if (state_q == ST_REQ_FIN) begin
      mem_we = 1'b1;
    end
  end

  // shuffle table memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= lcg_next;
    end
    if (issue) begin
      rd_q  <= mem_q[idx];
      idx_q <= idx;
    end
  end

  // sequencer, generator state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      seed_q      <= -32'sd1;
      gen_q       <= '0;
      held_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      out_value_q <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        seed_q <= cfg_wdata_i;
        held_q <= '0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_accept && request_i) begin
            if (held_q == '0) begin
              gen_q   <= start_val;
              cnt_q   <= '0;
              state_q <= ST_SEED_MUL;
            end else begin
              state_q <= ST_REQ_FIN;
            end
          end
        end
        ST_SEED_MUL: begin
          state_q <= ST_SEED_RED;
        end
        ST_SEED_RED: begin
          gen_q <= lcg_next;
          if (cnt_q == LAST_CNT) begin
            held_q  <= lcg_next;
            state_q <= ST_REQ_ISSUE;
          end else begin
            cnt_q   <= cnt_q + 1'b1;
            state_q <= ST_SEED_MUL;
          end
        end
        ST_REQ_ISSUE: begin
          state_q <= ST_REQ_FIN;
        end
        ST_REQ_FIN: begin
          gen_q       <= lcg_next;
          held_q      <= rd_q;
          out_value_q <= rd_q;
          out_valid_q <= 1'b1;
          state_q     <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // a new result only ever comes out of the write-back cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_REQ_FIN))
    else $error("result appeared outside write-back");

  // shuffled values are never the stuck generator value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (value_o != '0))
    else $error("zero value delivered");

  // the post-seeding request step follows only the last fill step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_REQ_ISSUE) |-> ($past(state_q == ST_SEED_RED) && (held_q != '0)))
    else $error("request step without completed seeding");

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for shuffled_minimal_standard_rng: predicts each value of the
// shuffled 16807 generator, reseeds through the seed register, random idling on both sides.
// Depends on smsrng_pkg and the RTL of the block; nothing else.
`timescale 1ns / 1ps

module tb;

  // cycles without any handshake before the run is declared hung
  localparam int unsigned HANG_LIMIT = 2000;
  // cycles let pass after the last value before touching the seed or ending
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned MAX_REPORTS = 50;

  // generator predictor and store of predicted values
  class shuffle_scoreboard;
    logic signed [31:0]             seed_word;
    logic [smsrng_pkg::VAL_W-1:0]   lcg_state;
    logic [smsrng_pkg::VAL_W-1:0]   last_value;
    logic [smsrng_pkg::VAL_W-1:0]   shuffle_tbl [smsrng_pkg::TABLE_SIZE];
    logic [smsrng_pkg::VAL_W-1:0]   predicted_values [$];
    int unsigned                    mismatches;
    int unsigned                    checked;

    function new();
      seed_word  = -32'sd1;
      lcg_state  = '0;
      last_value = '0;
      mismatches = 0;
      checked    = 0;
    endfunction

    function logic [smsrng_pkg::VAL_W-1:0] lcg_advance(logic [smsrng_pkg::VAL_W-1:0] x);
      logic [63:0] prod;
      logic [63:0] rem;
      prod = 64'(x) * 64'(smsrng_pkg::MULT);
      rem  = prod % 64'(smsrng_pkg::MODULUS);
      return rem[smsrng_pkg::VAL_W-1:0];
    endfunction

    // start value, discarded warm-up steps, table filled top entry down
    function void reseed();
      logic [31:0]                  mag;
      logic [31:0]                  start;
      logic [smsrng_pkg::VAL_W-1:0] x;
      int                           k;
      if (seed_word[31]) begin
        mag   = 32'd0 - seed_word;
        start = mag % {1'b0, smsrng_pkg::MODULUS};
        x     = (start == 32'd0) ? 31'd1 : start[smsrng_pkg::VAL_W-1:0];
      end else begin
        x = 31'd1;
      end
      for (k = 0; k < smsrng_pkg::DISCARD_STEPS; k++) x = lcg_advance(x);
      for (k = smsrng_pkg::TABLE_SIZE - 1; k >= 0; k--) begin
        x = lcg_advance(x);
        shuffle_tbl[k] = x;
      end
      lcg_state  = x;
      last_value = shuffle_tbl[0];
    endfunction

    function void write_seed(logic signed [31:0] s);
      seed_word  = s;
      last_value = '0;
    endfunction

    // one accepted input item; a dropped item predicts nothing
    function void note_request(logic req);
      int unsigned slot;
      if (!req) return;
      if (last_value == '0) reseed();
      lcg_state = lcg_advance(lcg_state);
      slot = last_value / smsrng_pkg::BUCKET;
      if (slot >= smsrng_pkg::TABLE_SIZE) slot = slot % smsrng_pkg::TABLE_SIZE;
      last_value        = shuffle_tbl[slot];
      shuffle_tbl[slot] = lcg_state;
      predicted_values.push_back(last_value);
    endfunction

    function int unsigned pending();
      return predicted_values.size();
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      // printing is capped, counting is not
      if (mismatches <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_value(logic [smsrng_pkg::VAL_W-1:0] got);
      logic [smsrng_pkg::VAL_W-1:0] want;
      if (predicted_values.size() == 0) begin
        report_mismatch($sformatf("value %0d arrived with no request outstanding", got));
        return;
      end
      want = predicted_values.pop_front();
      checked++;
      if (got !== want) report_mismatch($sformatf("value %0d, predicted %0d", got, want));
    endtask
  endclass

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           in_valid_i = 1'b0;
  logic                           in_stall_o;
  logic                           request_i = 1'b0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  logic [smsrng_pkg::VAL_W-1:0]   value_o;
  logic                           cfg_we_i = 1'b0;
  logic signed [31:0]             cfg_wdata_i = '0;

  logic        idle_on = 1'b0;
  logic        stall_on = 1'b0;
  int unsigned stall_run = 0;
  int unsigned quiet_cycles = 0;
  int unsigned requests_sent = 0;
  int unsigned dropped_sent = 0;
  int unsigned seed_writes = 0;

  shuffle_scoreboard sb = new();

  shuffled_minimal_standard_rng u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .request_i   (request_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_o     (value_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // mostly short spans, a few long ones
  function automatic int unsigned span_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 30);
    return $urandom_range(0, 2);
  endfunction

  // receiver backpressure
  always @(posedge clk_i) begin
    if (stall_run != 0) begin
      stall_run <= stall_run - 1;
    end else begin
      out_stall_i <= stall_on && ($urandom_range(0, 2) == 0);
      stall_run   <= span_len();
    end
  end

  // check every value that leaves the block
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_value(value_o);
  end

  // hang detection
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("[%0t] no handshake for %0d cycles", $time, HANG_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // offer one item, hold it until taken, then maybe idle
  task automatic send_item(input logic req);
    int unsigned gap;
    in_valid_i <= 1'b1;
    request_i  <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_request(req);
    if (req) requests_sent++;
    else dropped_sent++;
    gap = (idle_on && ($urandom_range(0, 2) == 0)) ? span_len() : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // stop sending and wait for every predicted value
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // seed writes only while the block is idle
  task automatic write_seed(input logic signed [31:0] s);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= s;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_seed(s);
    seed_writes++;
  endtask

  task automatic send_requests(input int unsigned n);
    repeat (n) send_item(1'b1);
  endtask

  function automatic logic signed [31:0] pick_seed();
    int unsigned r;
    r = $urandom_range(0, 9);
    case (r)
      0: return -32'sh8000_0000;
      1: return -32'sh7FFF_FFFF;
      2: return 32'sh7FFF_FFFF;
      3: return $signed($urandom() & 32'h7FFF_FFFF);
      4: return -$signed($urandom_range(1, 1000));
      default: return -$signed($urandom_range(1, 32'h7FFF_FFFF));
    endcase
  endfunction

  initial begin
    int unsigned n;
    int unsigned done;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset seed, dropped items before and after seeding
    send_item(1'b0);
    send_requests(4);
    send_item(1'b0);
    send_requests(3);
    // seed of minus modulus falls back to a start of one
    write_seed(-32'sh7FFF_FFFF);
    send_requests(3);
    // most negative seed reduces to one as well
    write_seed(-32'sh8000_0000);
    send_requests(3);
    // zero and positive seeds start at one
    write_seed(32'sd0);
    send_requests(2);
    write_seed(32'sh7FFF_FFFF);
    send_requests(2);
    write_seed(32'sd1);
    send_requests(1);
    write_seed(-32'sd1);
    send_requests(2);

    // random phases, some without any idling
    for (int ph = 0; ph < 12; ph++) begin
      drain();
      idle_on  <= (ph % 4 != 1);
      stall_on <= (ph % 4 != 1);
      if (ph != 3) write_seed(pick_seed());
      n    = $urandom_range(100, 125);
      done = 0;
      while (done < n) begin
        if ($urandom_range(0, 9) == 0) begin
          send_item(1'b0);
        end else begin
          send_item(1'b1);
          done++;
        end
        // sender holds off until every value is back
        if (ph == 5 && done == n / 2) drain();
      end
    end

    drain();
    $display("Run covered %0d requests and %0d dropped items over %0d seed writes.",
             requests_sent, dropped_sent, seed_writes);
    $display("%0d values compared, %0d mismatches.", sb.checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: shuffled_minimal_standard_rng.f
rtl/core/smsrng_pkg.sv
rtl/core/smsrng_lcg.sv
rtl/core/shuffled_minimal_standard_rng.sv
tb/tb.sv
